[rtl/dad_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package dad_pkg;

  localparam int ANGLE_STAGES = 24;
  localparam int IDX_W = $clog2(ANGLE_STAGES);

  localparam int COORD_W = 32;
  localparam int DIFF_W = COORD_W + 1;
  localparam int FRAC_SHIFT = 24;
  localparam int XY_W = 60;
  localparam int ACC_W = 34;
  localparam int SUM_W = ACC_W + 1;
  localparam int HEAD_W = 26;
  localparam int RND_SHIFT = 8;
  localparam int RES_W = SUM_W - RND_SHIFT;

  localparam logic signed [ACC_W-1:0] DEG90_Q24 = 34'sd1509949440;
  localparam logic signed [RES_W-1:0] HEAD_MIN = -27'sd5898240;
  localparam logic signed [RES_W-1:0] HEAD_MAX = 27'sd17694720;
  localparam logic signed [HEAD_W-1:0] HEAD_90 = 26'sd5898240;
  localparam logic signed [HEAD_W-1:0] HEAD_NEG90 = -26'sd5898240;
  localparam logic signed [63:0] RAD_TO_DEG_Q24 = 64'sd961263669;

  typedef struct packed {
    logic [XY_W-1:0]  x;
    logic [XY_W-1:0]  y;
    logic [ACC_W-1:0] acc;
    logic             fixed;
    logic             fixed_neg;
  } cordic_t;

  // atan(2^-i) in degrees, 24 fraction bits
  function automatic logic signed [ACC_W-1:0] atan_q24(input logic [IDX_W-1:0] i);
    logic [7:0]         n;
    logic signed [63:0] v;
    n = 8'(i);
    unique case (n)
      8'd0:    v = 64'sd754974720;
      8'd1:    v = 64'sd445687602;
      8'd2:    v = 64'sd235489088;
      8'd3:    v = 64'sd119537938;
      8'd4:    v = 64'sd60000934;
      8'd5:    v = 64'sd30029717;
      8'd6:    v = 64'sd15018523;
      8'd7:    v = 64'sd7509720;
      8'd8:    v = 64'sd3754917;
      8'd9:    v = 64'sd1877466;
      8'd10:   v = 64'sd938734;
      8'd11:   v = 64'sd469367;
      8'd12:   v = 64'sd234684;
      8'd13:   v = 64'sd117342;
      8'd14:   v = 64'sd58671;
      8'd15:   v = 64'sd29335;
      default: v = (RAD_TO_DEG_Q24 + (64'sd1 <<< (n - 8'd1))) >>> n;
    endcase
    return ACC_W'(v);
  endfunction

endpackage

`default_nettype wire

[rtl/dad_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface dad_in_if;
  logic                                valid;
  logic                                ready;
  logic signed [dad_pkg::COORD_W-1:0] origin_x;
  logic signed [dad_pkg::COORD_W-1:0] origin_y;
  logic signed [dad_pkg::COORD_W-1:0] dest_x;
  logic signed [dad_pkg::COORD_W-1:0] dest_y;

  modport source (output valid, origin_x, origin_y, dest_x, dest_y, input ready);
  modport sink (input valid, origin_x, origin_y, dest_x, dest_y, output ready);
  modport monitor (input valid, ready, origin_x, origin_y, dest_x, dest_y);
endinterface

interface dad_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [dad_pkg::HEAD_W-1:0] heading_deg;

  modport source (output valid, heading_deg, input ready);
  modport sink (input valid, heading_deg, output ready);
  modport monitor (input valid, ready, heading_deg);
endinterface

`default_nettype wire

[rtl/dad_prep.sv]
`timescale 1ns / 1ps
`default_nettype none

module dad_prep (
  input  logic              clk,
  input  logic              rst_n,
  dad_in_if.sink            in_ch,
  output logic              out_valid,
  input  logic              out_ready,
  output dad_pkg::cordic_t  out_data
);

  logic                               valid_r;
  dad_pkg::cordic_t                   data_r;
  dad_pkg::cordic_t                   data_nxt;
  logic signed [dad_pkg::DIFF_W-1:0]  dx;
  logic signed [dad_pkg::DIFF_W-1:0]  dy;
  logic signed [dad_pkg::DIFF_W-1:0]  xa;
  logic signed [dad_pkg::DIFF_W-1:0]  ya;
  logic signed [dad_pkg::ACC_W-1:0]   acc0;

  localparam int PAD_W = dad_pkg::XY_W - dad_pkg::DIFF_W - dad_pkg::FRAC_SHIFT;

  assign in_ch.ready = !valid_r || out_ready;

  always_comb begin
    dx = $signed({in_ch.dest_x[dad_pkg::COORD_W-1], in_ch.dest_x})
       - $signed({in_ch.origin_x[dad_pkg::COORD_W-1], in_ch.origin_x});
    dy = $signed({in_ch.dest_y[dad_pkg::COORD_W-1], in_ch.dest_y})
       - $signed({in_ch.origin_y[dad_pkg::COORD_W-1], in_ch.origin_y});
    // left half plane: quarter turn so that x starts non-negative
    if (dx < 0 && dy > 0) begin
      xa   = dy;
      ya   = -dx;
      acc0 = dad_pkg::DEG90_Q24;
    end else if (dx < 0) begin
      xa   = -dy;
      ya   = dx;
      acc0 = -dad_pkg::DEG90_Q24;
    end else begin
      xa   = dx;
      ya   = dy;
      acc0 = '0;
    end
    data_nxt.x         = {{PAD_W{xa[dad_pkg::DIFF_W-1]}}, xa, dad_pkg::FRAC_SHIFT'(0)};
    data_nxt.y         = {{PAD_W{ya[dad_pkg::DIFF_W-1]}}, ya, dad_pkg::FRAC_SHIFT'(0)};
    data_nxt.acc       = acc0;
    data_nxt.fixed     = (dy == 0);
    data_nxt.fixed_neg = (dx < 0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

[rtl/dad_cell.sv]
`timescale 1ns / 1ps
`default_nettype none

module dad_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [dad_pkg::IDX_W-1:0]  stage_idx,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  dad_pkg::cordic_t           in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output dad_pkg::cordic_t           out_data
);

  logic                              valid_r;
  dad_pkg::cordic_t                  data_r;
  dad_pkg::cordic_t                  data_nxt;
  logic signed [dad_pkg::XY_W-1:0]   x;
  logic signed [dad_pkg::XY_W-1:0]   y;
  logic signed [dad_pkg::XY_W-1:0]   xs;
  logic signed [dad_pkg::XY_W-1:0]   ys;
  logic signed [dad_pkg::ACC_W-1:0]  acc;
  logic signed [dad_pkg::ACC_W-1:0]  step;

  assign in_ready = !valid_r || out_ready;

  always_comb begin
    x    = $signed(in_data.x);
    y    = $signed(in_data.y);
    acc  = $signed(in_data.acc);
    xs   = x >>> stage_idx;
    ys   = y >>> stage_idx;
    step = dad_pkg::atan_q24(stage_idx);
    data_nxt = in_data;
    if (y < 0) begin
      data_nxt.x   = x - ys;
      data_nxt.y   = y + xs;
      data_nxt.acc = acc - step;
    end else begin
      data_nxt.x   = x + ys;
      data_nxt.y   = y - xs;
      data_nxt.acc = acc + step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= data_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

`default_nettype wire

[rtl/dad_post.sv]
`timescale 1ns / 1ps
`default_nettype none

module dad_post (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  dad_pkg::cordic_t  in_data,
  dad_out_if.source         out_ch
);

  localparam int SUM_W = dad_pkg::SUM_W;
  localparam int RES_W = dad_pkg::RES_W;

  logic                               valid_r;
  logic signed [dad_pkg::HEAD_W-1:0]  head_r;
  logic signed [dad_pkg::HEAD_W-1:0]  head_nxt;
  logic signed [dad_pkg::SUM_W-1:0]   sum;
  logic signed [dad_pkg::RES_W-1:0]   res;

  assign in_ready = !valid_r || out_ch.ready;

  always_comb begin
    // add 90, round half up to 16 fraction bits, then clamp to -90..270; dy == 0 gives a fixed +90 or -90
    sum = SUM_W'($signed(in_data.acc)) + SUM_W'(dad_pkg::DEG90_Q24) + SUM_W'(128);
    res = RES_W'(sum >>> dad_pkg::RND_SHIFT);
    if (in_data.fixed) begin
      head_nxt = in_data.fixed_neg ? dad_pkg::HEAD_NEG90 : dad_pkg::HEAD_90;
    end else if (res < dad_pkg::HEAD_MIN) begin
      head_nxt = dad_pkg::HEAD_W'(dad_pkg::HEAD_MIN);
    end else if (res > dad_pkg::HEAD_MAX) begin
      head_nxt = dad_pkg::HEAD_W'(dad_pkg::HEAD_MAX);
    end else begin
      head_nxt = dad_pkg::HEAD_W'(res);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      head_r <= head_nxt;
    end
  end

  assign out_ch.valid       = valid_r;
  assign out_ch.heading_deg = head_r;

endmodule

`default_nettype wire

[rtl/direction_angle_degrees_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Heading from an origin point to a destination point, in degrees with 16
// fraction bits (-90 to 270), computed as 90 + atan2(dy, dx) by a vectoring
// CORDIC laid out as a row of dad_pkg::ANGLE_STAGES identical cells. One item
// is taken every cycle while in_ch.ready is high; each item passes in order
// through one difference and quadrant stage, one cell per CORDIC iteration
// and one rounding and clamping stage that also holds the result. Every stage
// has its own valid bit and moves on when the stage after it is empty or
// moving, so bubbles close up under output back-pressure and in_ch.ready
// stays high while any stage is free.
module direction_angle_degrees_core (
  input  logic       clk,
  input  logic       rst_n,
  dad_in_if.sink     in_ch,
  dad_out_if.source  out_ch
);

  localparam int N = dad_pkg::ANGLE_STAGES;

  logic             chain_valid [N+1];
  logic             chain_ready [N+1];
  dad_pkg::cordic_t chain_data  [N+1];

  dad_prep u_prep (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_valid (chain_valid[0]),
    .out_ready (chain_ready[0]),
    .out_data  (chain_data[0])
  );

  for (genvar g = 0; g < N; g++) begin : g_cell
    dad_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .stage_idx (dad_pkg::IDX_W'(g)),
      .in_valid  (chain_valid[g]),
      .in_ready  (chain_ready[g]),
      .in_data   (chain_data[g]),
      .out_valid (chain_valid[g+1]),
      .out_ready (chain_ready[g+1]),
      .out_data  (chain_data[g+1])
    );
  end

  dad_post u_post (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (chain_valid[N]),
    .in_ready (chain_ready[N]),
    .in_data  (chain_data[N]),
    .out_ch   (out_ch)
  );

endmodule

`default_nettype wire

[rtl/dad_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module dad_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_ready,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic signed [dad_pkg::HEAD_W-1:0] heading_deg
);

  // results never leave the -90..270 range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (heading_deg >= dad_pkg::HEAD_NEG90 &&
                   heading_deg <= dad_pkg::HEAD_MAX))
    else $error("heading out of range");

  // reset empties the row
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // with nothing waiting at the output every stage can move
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

  // a waiting result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(heading_deg))
    else $error("result dropped or changed while stalled");

endmodule

bind direction_angle_degrees_core dad_checker u_dad_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .heading_deg (out_ch.heading_deg)
);

`default_nettype wire
